### rtl/core/inds_pkg.sv
package inds_pkg;

    localparam int ADC_BITS     = 12;
    localparam int CHANNELS     = 4;
    localparam int CH_BITS      = $clog2(CHANNELS);
    localparam int PULSE_BITS   = 12;
    localparam int LEVEL_BITS   = 7;
    localparam int SUM_BITS     = 9;
    localparam int TARGET_BITS  = 15;
    localparam int THRESH_BITS  = 7;
    localparam int GAIN_BITS    = 7;
    localparam int DUTY_BITS    = 16;
    localparam int DIFF_BITS    = LEVEL_BITS + 1;
    localparam int OFFSET_BITS  = DIFF_BITS + GAIN_BITS;
    localparam int DUTY_W       = 18;

    // numerator of the level divide is (x - min) * 100
    localparam int NUM_BITS     = ADC_BITS + 7;
    // offset * 8 needs OFFSET_BITS + 2 magnitude bits
    localparam int SCALE_BITS   = OFFSET_BITS + 2;
    localparam int DIV_BITS     = (NUM_BITS > SCALE_BITS) ? NUM_BITS : SCALE_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

    localparam int LEVEL_MAX    = 100;
    localparam int SCALE_DIV    = 5;
    localparam int CH_LV        = 1;
    localparam int CH_RV        = 2;

    localparam int REG_IDX_BITS = 2;
    localparam int PADDR_BITS   = REG_IDX_BITS + 2;
    localparam int PDATA_BITS   = 32;

    localparam logic [ADC_BITS-1:0] MIN_RESET = ADC_BITS'(120);
    localparam logic [ADC_BITS-1:0] MAX_RESET [CHANNELS] = '{
        ADC_BITS'(2500), ADC_BITS'(2300), ADC_BITS'(999), ADC_BITS'(999)
    };

    localparam logic signed [TARGET_BITS-1:0] TARGET_RESET = '0;
    localparam logic [THRESH_BITS-1:0]        THRESH_RESET = THRESH_BITS'(28);
    localparam logic [GAIN_BITS-1:0]          STRONG_RESET = GAIN_BITS'(20);
    localparam logic [GAIN_BITS-1:0]          WEAK_RESET   = GAIN_BITS'(35);

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_TARGET_DUTY,
        REG_STRONG_THRESHOLD,
        REG_GAIN_STRONG,
        REG_GAIN_WEAK
    } inds_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_SCALE,
        ST_SDIV,
        ST_DUTY
    } inds_state_t;

    typedef struct packed {
        logic [ADC_BITS-1:0]          left_parallel_sample;
        logic [ADC_BITS-1:0]          left_vertical_sample;
        logic [ADC_BITS-1:0]          right_vertical_sample;
        logic [ADC_BITS-1:0]          right_parallel_sample;
        logic signed [PULSE_BITS-1:0] pulses_motor_one;
        logic signed [PULSE_BITS-1:0] pulses_motor_two;
    } inds_in_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0]       level_left_parallel;
        logic [LEVEL_BITS-1:0]       level_left_vertical;
        logic [LEVEL_BITS-1:0]       level_right_vertical;
        logic [LEVEL_BITS-1:0]       level_right_parallel;
        logic [SUM_BITS-1:0]         field_strength;
        logic signed [DUTY_BITS-1:0] duty_motor_one;
        logic signed [DUTY_BITS-1:0] duty_motor_two;
    } inds_out_t;

    typedef struct packed {
        logic signed [TARGET_BITS-1:0] target_duty;
        logic [THRESH_BITS-1:0]        strong_threshold;
        logic [GAIN_BITS-1:0]          gain_strong;
        logic [GAIN_BITS-1:0]          gain_weak;
    } inds_cfg_t;

endpackage

### rtl/core/inds_div.sv
module inds_div
    import inds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_BITS-1:0] dividend,
    input  logic [ADC_BITS-1:0] divisor,
    output logic                done,
    output logic [DIV_BITS-1:0] quotient
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [ADC_BITS-1:0]     rem_reg, rem_next;
    logic [DIV_BITS-1:0]     quo_reg, quo_next;
    logic [ADC_BITS-1:0]     dvs_reg;
    logic [ADC_BITS:0]       partial;
    logic [ADC_BITS:0]       trial;
    logic                    fit;

    // one quotient bit a cycle, dividend shifted in from the top
    always_comb
    begin
        partial   = {rem_reg, quo_reg[DIV_BITS-1]};
        trial     = partial - {1'b0, dvs_reg};
        fit       = ~trial[ADC_BITS];
        rem_next  = fit ? trial[ADC_BITS-1:0] : partial[ADC_BITS-1:0];
        quo_next  = {quo_reg[DIV_BITS-2:0], fit};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(DIV_BITS);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/inds_regs.sv
module inds_regs
    import inds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output inds_cfg_t             cfg
);

    inds_cfg_t cfg_reg;
    inds_reg_t idx;
    logic      wr_en;

    assign idx    = inds_reg_t'(paddr[PADDR_BITS-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_duty      <= TARGET_RESET;
            cfg_reg.strong_threshold <= THRESH_RESET;
            cfg_reg.gain_strong      <= STRONG_RESET;
            cfg_reg.gain_weak        <= WEAK_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_TARGET_DUTY:      cfg_reg.target_duty      <= pwdata[TARGET_BITS-1:0];
                REG_STRONG_THRESHOLD: cfg_reg.strong_threshold <= pwdata[THRESH_BITS-1:0];
                REG_GAIN_STRONG:      cfg_reg.gain_strong      <= pwdata[GAIN_BITS-1:0];
                REG_GAIN_WEAK:        cfg_reg.gain_weak        <= pwdata[GAIN_BITS-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TARGET_DUTY:
                prdata = {{(PDATA_BITS-TARGET_BITS){cfg_reg.target_duty[TARGET_BITS-1]}},
                          cfg_reg.target_duty};
            REG_STRONG_THRESHOLD:
                prdata = PDATA_BITS'(cfg_reg.strong_threshold);
            REG_GAIN_STRONG:
                prdata = PDATA_BITS'(cfg_reg.gain_strong);
            REG_GAIN_WEAK:
                prdata = PDATA_BITS'(cfg_reg.gain_weak);
            default:
                prdata = '0;
        endcase
    end

endmodule

### rtl/core/inductor_normalize_differential_steer.sv
// Inductor normalisation and differential steering.
//
// Input channel (sample_valid / sample_ready / sample): one beat carries four
// inductor samples and two encoder pulse counts. Output channel (result_valid /
// result_ready / result): one beat per input beat with four levels in percent,
// their sum and the two saturated motor duties.
// Each beat runs through one shared bit-serial divider: four level divides and
// one divide by five for the steering scale, one quotient bit a cycle. The next
// input beat is taken no earlier than the cycle after the result is loaded;
// the block takes no new beat while its divides run.
// A finished result sits in an output register; the block accepts the next
// beat while it waits. If the receiver still stalls when the next result is
// ready, the block holds in its last step until the register is free.
// Reset puts the running minima at 120 and the maxima at 2500, 2300, 999, 999,
// loads the register defaults and empties the output register. The user must
// write registers over the APB port while idle; the block does not enforce it.
module inductor_normalize_differential_steer
    import inds_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  inds_in_t              sample,
    output logic                  result_valid,
    input  logic                  result_ready,
    output inds_out_t             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    localparam logic signed [DUTY_W-1:0] SAT_HI = DUTY_W'(32767);
    localparam logic signed [DUTY_W-1:0] SAT_LO = DUTY_W'(-32768);

    inds_cfg_t   cfg;
    inds_state_t state_reg, state_next;

    logic [ADC_BITS-1:0]          samp_reg [CHANNELS];
    logic [ADC_BITS-1:0]          min_reg  [CHANNELS];
    logic [ADC_BITS-1:0]          max_reg  [CHANNELS];
    logic [LEVEL_BITS-1:0]        lvl_reg  [CHANNELS];
    logic signed [PULSE_BITS-1:0] p1_reg, p2_reg;
    logic [CH_BITS-1:0]           ch_reg;
    logic [SUM_BITS-1:0]          sum_reg;
    logic                         empty_reg;
    logic signed [OFFSET_BITS-1:0] offset_reg;
    logic                         neg_reg;
    logic signed [DUTY_W-1:0]     scaled_reg;
    inds_out_t                    result_reg;
    logic                         result_valid_reg;

    logic                accept;
    logic                div_start, div_done;
    logic                cap_level, cap_scaled, load_result;
    logic [DIV_BITS-1:0] div_dividend, quotient;
    logic [ADC_BITS-1:0] div_divisor;

    logic [ADC_BITS-1:0] x, lo, hi, span, dx;
    logic                lower, raise, empty;
    logic [DIV_BITS-1:0] dx_w, num;
    logic [LEVEL_BITS-1:0] level;
    logic signed [DIFF_BITS-1:0] diff;
    logic [GAIN_BITS-1:0] gain;
    logic signed [2*DIFF_BITS-1:0] product;
    logic [OFFSET_BITS-1:0] mag;
    logic signed [DUTY_W-1:0] qs, tgt, p1x, p2x, d1, d2;
    logic signed [DUTY_BITS-1:0] d1_sat, d2_sat;

    inds_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    inds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (sample_valid) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = (ch_reg == CH_BITS'(CHANNELS - 1)) ? ST_MUL : ST_LOAD;
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_SDIV;
            ST_SDIV:  if (div_done) state_next = ST_DUTY;
            ST_DUTY:  if (!result_valid_reg || result_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        sample_ready = 1'b0;
        div_start    = 1'b0;
        cap_level    = 1'b0;
        cap_scaled   = 1'b0;
        load_result  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  sample_ready = 1'b1;
            ST_LOAD:  div_start    = 1'b1;
            ST_DIV:   cap_level    = div_done;
            ST_MUL:   ;
            ST_SCALE: div_start    = 1'b1;
            ST_SDIV:  cap_scaled   = div_done;
            ST_DUTY:  load_result  = !result_valid_reg || result_ready;
            default:  ;
        endcase
    end

    assign accept = sample_valid & sample_ready;

    // channel update and level divide operands
    always_comb
    begin
        x     = samp_reg[ch_reg];
        lower = x < min_reg[ch_reg];
        raise = !lower && (x > max_reg[ch_reg]);
        lo    = lower ? x : min_reg[ch_reg];
        hi    = raise ? x : max_reg[ch_reg];
        empty = hi <= lo;
        span  = hi - lo;
        dx    = x - lo;
        dx_w  = DIV_BITS'(dx);
        num   = (dx_w << 6) + (dx_w << 5) + (dx_w << 2);
        level = (quotient > DIV_BITS'(LEVEL_MAX)) ? LEVEL_BITS'(LEVEL_MAX)
                                                  : quotient[LEVEL_BITS-1:0];
        if (empty_reg)
            level = '0;
    end

    // steering offset and scale operands
    always_comb
    begin
        gain    = (lvl_reg[CH_LV] > cfg.strong_threshold &&
                   lvl_reg[CH_RV] > cfg.strong_threshold) ? cfg.gain_strong : cfg.gain_weak;
        diff    = $signed({1'b0, lvl_reg[CH_LV]}) - $signed({1'b0, lvl_reg[CH_RV]});
        product = diff * $signed({1'b0, gain});
        mag     = offset_reg[OFFSET_BITS-1] ? OFFSET_BITS'(-offset_reg)
                                            : OFFSET_BITS'(offset_reg);
        if (state_reg == ST_SCALE)
        begin
            div_dividend = DIV_BITS'(mag) << 3;
            div_divisor  = ADC_BITS'(SCALE_DIV);
        end
        else
        begin
            div_dividend = num;
            div_divisor  = span;
        end
    end

    // duties, saturated
    always_comb
    begin
        qs   = DUTY_W'(quotient[DUTY_W-1:0]);
        tgt  = DUTY_W'(cfg.target_duty);
        p1x  = DUTY_W'(p1_reg);
        p2x  = DUTY_W'(p2_reg);
        d1   = tgt - scaled_reg - ((p1x <<< 1) + p1x);
        d2   = tgt + scaled_reg + ((p2x <<< 1) + p2x);
        if (d1 > SAT_HI)
            d1_sat = DUTY_BITS'(SAT_HI);
        else if (d1 < SAT_LO)
            d1_sat = DUTY_BITS'(SAT_LO);
        else
            d1_sat = d1[DUTY_BITS-1:0];
        if (d2 > SAT_HI)
            d2_sat = DUTY_BITS'(SAT_HI);
        else if (d2 < SAT_LO)
            d2_sat = DUTY_BITS'(SAT_LO);
        else
            d2_sat = d2[DUTY_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ch_reg           <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                min_reg[i] <= MIN_RESET;
                max_reg[i] <= MAX_RESET[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                ch_reg <= '0;
            else if (cap_level)
                ch_reg <= ch_reg + 1'b1;
            if (state_reg == ST_LOAD)
            begin
                if (lower)
                    min_reg[ch_reg] <= x;
                if (raise)
                    max_reg[ch_reg] <= x;
            end
            if (load_result)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg[0] <= sample.left_parallel_sample;
            samp_reg[1] <= sample.left_vertical_sample;
            samp_reg[2] <= sample.right_vertical_sample;
            samp_reg[3] <= sample.right_parallel_sample;
            p1_reg      <= sample.pulses_motor_one;
            p2_reg      <= sample.pulses_motor_two;
            sum_reg     <= '0;
        end
        if (state_reg == ST_LOAD)
            empty_reg <= empty;
        if (cap_level)
        begin
            lvl_reg[ch_reg] <= level;
            sum_reg         <= sum_reg + SUM_BITS'(level);
        end
        if (state_reg == ST_MUL)
            offset_reg <= product[OFFSET_BITS-1:0];
        if (state_reg == ST_SCALE)
            neg_reg <= offset_reg[OFFSET_BITS-1];
        if (cap_scaled)
            scaled_reg <= neg_reg ? -qs : qs;
        if (load_result)
        begin
            result_reg.level_left_parallel  <= lvl_reg[0];
            result_reg.level_left_vertical  <= lvl_reg[1];
            result_reg.level_right_vertical <= lvl_reg[2];
            result_reg.level_right_parallel <= lvl_reg[3];
            result_reg.field_strength       <= sum_reg;
            result_reg.duty_motor_one       <= d1_sat;
            result_reg.duty_motor_two       <= d2_sat;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/core/inds_checker.sv
module inds_checker
    import inds_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      sample_valid,
    input logic      sample_ready,
    input logic      result_valid,
    input logic      result_ready,
    input inds_out_t result
);

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat changed under stall");

    // input drops ready once a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("input taken again while an item is in flight");

    // a new result frees the input side at once
    a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> sample_ready)
        else $error("block not idle when result appeared");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.level_left_parallel <= LEVEL_BITS'(LEVEL_MAX)
                      && result.level_left_vertical <= LEVEL_BITS'(LEVEL_MAX)
                      && result.level_right_vertical <= LEVEL_BITS'(LEVEL_MAX)
                      && result.level_right_parallel <= LEVEL_BITS'(LEVEL_MAX))
        else $error("level above full scale");

    a_strength_sum: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.field_strength ==
            SUM_BITS'(result.level_left_parallel) + SUM_BITS'(result.level_left_vertical)
          + SUM_BITS'(result.level_right_vertical) + SUM_BITS'(result.level_right_parallel))
        else $error("field strength differs from level sum");

endmodule

bind inductor_normalize_differential_steer inds_checker u_inds_checker (.*);

### tb/sv/tb_inductor_normalize_differential_steer.sv
`timescale 1ns / 1ps

module tb_inductor_normalize_differential_steer;
    import inds_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_ready;
    inds_in_t              sample;
    logic                  result_valid;
    logic                  result_ready;
    inds_out_t             result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    inductor_normalize_differential_steer dut (.*);

    // tracked span per channel and register copies
    logic [ADC_BITS-1:0]           span_min [CHANNELS];
    logic [ADC_BITS-1:0]           span_max [CHANNELS];
    logic signed [TARGET_BITS-1:0] cfg_target;
    logic [THRESH_BITS-1:0]        cfg_thresh;
    logic [GAIN_BITS-1:0]          cfg_strong;
    logic [GAIN_BITS-1:0]          cfg_weak;

    inds_out_t steer_q [$];

    int  errors;
    int  samples_sent;
    int  results_seen;
    int  cfg_writes;
    int  duty_clamps;
    bit  no_idle;
    int  hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // give up on a hang
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int clamp_duty(int v);
        if (v > 32767)
        begin
            duty_clamps++;
            return 32767;
        end
        if (v < -32768)
        begin
            duty_clamps++;
            return -32768;
        end
        return v;
    endfunction

    function automatic inds_out_t steer_predict(inds_in_t s);
        int        x [CHANNELS];
        int        lvl [CHANNELS];
        int        c;
        int        lo;
        int        hi;
        int        sum;
        int        gain;
        int        scaled;
        inds_out_t r;
        x[0] = s.left_parallel_sample;
        x[1] = s.left_vertical_sample;
        x[2] = s.right_vertical_sample;
        x[3] = s.right_parallel_sample;
        sum = 0;
        for (c = 0; c < CHANNELS; c++)
        begin
            lo = span_min[c];
            hi = span_max[c];
            // a low sample moves the floor; only otherwise may it move the ceiling
            if (x[c] < lo)
            begin
                span_min[c] = ADC_BITS'(x[c]);
                lo = x[c];
            end
            else if (x[c] > hi)
            begin
                span_max[c] = ADC_BITS'(x[c]);
                hi = x[c];
            end
            lvl[c] = (hi <= lo) ? 0 : (x[c] - lo) * 100 / (hi - lo);
            if (lvl[c] > 100)
                lvl[c] = 100;
            sum += lvl[c];
        end
        gain = (lvl[CH_LV] > int'(cfg_thresh) && lvl[CH_RV] > int'(cfg_thresh))
               ? int'(cfg_strong) : int'(cfg_weak);
        // integer divide truncates toward zero, as the steering scale needs
        scaled = ((lvl[CH_LV] - lvl[CH_RV]) * gain * 8) / 5;
        r.level_left_parallel  = LEVEL_BITS'(lvl[0]);
        r.level_left_vertical  = LEVEL_BITS'(lvl[1]);
        r.level_right_vertical = LEVEL_BITS'(lvl[2]);
        r.level_right_parallel = LEVEL_BITS'(lvl[3]);
        r.field_strength       = SUM_BITS'(sum);
        r.duty_motor_one = DUTY_BITS'(clamp_duty(int'(cfg_target) - scaled
                                                 - 3 * int'(s.pulses_motor_one)));
        r.duty_motor_two = DUTY_BITS'(clamp_duty(int'(cfg_target) + scaled
                                                 + 3 * int'(s.pulses_motor_two)));
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // result checker
    initial
    begin
        inds_out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (steer_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with nothing expected, expected none got %p",
                             $time, result);
                end
                else
                begin
                    want = steer_q.pop_front();
                    results_seen++;
                    check_field("level_left_parallel", want.level_left_parallel,
                                result.level_left_parallel);
                    check_field("level_left_vertical", want.level_left_vertical,
                                result.level_left_vertical);
                    check_field("level_right_vertical", want.level_right_vertical,
                                result.level_right_vertical);
                    check_field("level_right_parallel", want.level_right_parallel,
                                result.level_right_parallel);
                    check_field("field_strength", want.field_strength,
                                result.field_strength);
                    check_field("duty_motor_one", want.duty_motor_one,
                                result.duty_motor_one);
                    check_field("duty_motor_two", want.duty_motor_two,
                                result.duty_motor_two);
                end
            end
        end
    end

    // receiver: after each beat stall for hold_cycles if set, else for a random time unless no_idle is set
    initial
    begin
        int stall;
        result_ready = 1'b1;
        @(posedge rst_n);
        forever
        begin
            do @(posedge clk); while (!(result_valid && result_ready));
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                @(negedge clk);
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
                result_ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(int lp, int lv, int rv, int rp, int p1, int p2);
        int       gap;
        inds_in_t s;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        s.left_parallel_sample  = ADC_BITS'(lp);
        s.left_vertical_sample  = ADC_BITS'(lv);
        s.right_vertical_sample = ADC_BITS'(rv);
        s.right_parallel_sample = ADC_BITS'(rp);
        s.pulses_motor_one      = PULSE_BITS'(p1);
        s.pulses_motor_two      = PULSE_BITS'(p2);
        repeat (gap) @(negedge clk);
        @(negedge clk);
        sample       <= s;
        sample_valid <= 1'b1;
        do @(posedge clk); while (!sample_ready);
        steer_q.push_back(steer_predict(s));
        samples_sent++;
        @(negedge clk);
        sample_valid <= 1'b0;
    endtask

    task automatic cfg_write(inds_reg_t idx, logic [PDATA_BITS-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_BITS'({idx, 2'b00});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_TARGET_DUTY:      cfg_target = val[TARGET_BITS-1:0];
            REG_STRONG_THRESHOLD: cfg_thresh = val[THRESH_BITS-1:0];
            REG_GAIN_STRONG:      cfg_strong = val[GAIN_BITS-1:0];
            REG_GAIN_WEAK:        cfg_weak   = val[GAIN_BITS-1:0];
            default:              ;
        endcase
        cfg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (steer_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_sample();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // reset register values; span grows from reset bounds to full scale
    task automatic test_defaults();
        send_sample(1300, 1200, 500, 500, 0, 0);
        send_sample(2600, 2400, 1100, 1100, 5, -5);
        send_sample(100, 100, 100, 100, -7, 7);
        send_sample(4095, 4095, 4095, 4095, 2047, 2047);
        send_sample(0, 0, 0, 0, -2048, -2048);
        send_sample(2048, 4095, 0, 2048, 0, 0);
        send_sample(2048, 0, 4095, 2048, 0, 0);
        send_sample(2730, 1365, 2730, 1365, 1365, -1366);
        send_sample(1365, 2730, 1365, 2730, -1366, 1365);
        send_sample(3000, 3500, 3600, 1000, 100, -100);
    endtask

    // both verticals must be strictly above the threshold for the strong gain
    task automatic test_threshold();
        wait_drained();
        cfg_write(REG_STRONG_THRESHOLD, 50);
        cfg_write(REG_GAIN_STRONG, 10);
        cfg_write(REG_GAIN_WEAK, 90);
        send_sample(0, 2089, 2048, 0, 0, 0);
        send_sample(0, 2130, 2089, 0, 0, 0);
        send_sample(0, 2048, 2089, 0, 0, 0);
        wait_drained();
        cfg_write(REG_STRONG_THRESHOLD, 0);
        send_sample(0, 41, 0, 0, 0, 0);
        send_sample(0, 82, 41, 0, 0, 0);
        wait_drained();
        cfg_write(REG_STRONG_THRESHOLD, 127);
        send_sample(0, 4095, 2048, 0, 0, 0);
    endtask

    // drive both duties past either rail, then zero gain
    task automatic test_saturation();
        wait_drained();
        cfg_write(REG_TARGET_DUTY, 16383);
        cfg_write(REG_GAIN_STRONG, 127);
        cfg_write(REG_GAIN_WEAK, 127);
        cfg_write(REG_STRONG_THRESHOLD, 0);
        send_sample(0, 0, 4095, 0, -2048, 0);
        send_sample(0, 4095, 0, 0, 2047, 2047);
        wait_drained();
        cfg_write(REG_TARGET_DUTY, 32'hFFFF_C000);
        send_sample(0, 0, 4095, 0, 0, -2048);
        send_sample(0, 4095, 0, 0, 2047, 0);
        wait_drained();
        cfg_write(REG_TARGET_DUTY, 0);
        cfg_write(REG_GAIN_STRONG, 0);
        cfg_write(REG_GAIN_WEAK, 0);
        send_sample(0, 4095, 0, 0, 0, 0);
    endtask

    // hold the receiver off long enough that the block stalls its input
    task automatic test_backpressure();
        int n;
        wait_drained();
        cfg_write(REG_GAIN_STRONG, STRONG_RESET);
        cfg_write(REG_GAIN_WEAK, WEAK_RESET);
        hold_cycles = 600;
        no_idle = 1'b1;
        for (n = 0; n < 6; n++)
            send_sample(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                        $urandom_range(0, 4095), $urandom_range(0, 4095));
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        int phase;
        int n;
        for (phase = 0; phase < 14; phase++)
        begin
            wait_drained();
            cfg_write(REG_TARGET_DUTY, $urandom());
            cfg_write(REG_STRONG_THRESHOLD, $urandom());
            cfg_write(REG_GAIN_STRONG, $urandom());
            cfg_write(REG_GAIN_WEAK, $urandom());
            no_idle = ($urandom_range(0, 3) == 0);
            for (n = 0; n < 100; n++)
                send_sample(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                            $urandom_range(0, 4095), $urandom_range(0, 4095));
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        int c;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        no_idle      = 1'b0;
        hold_cycles  = 0;
        errors       = 0;
        samples_sent = 0;
        results_seen = 0;
        cfg_writes   = 0;
        duty_clamps  = 0;
        for (c = 0; c < CHANNELS; c++)
        begin
            span_min[c] = MIN_RESET;
            span_max[c] = MAX_RESET[c];
        end
        cfg_target = TARGET_RESET;
        cfg_thresh = THRESH_RESET;
        cfg_strong = STRONG_RESET;
        cfg_weak   = WEAK_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_defaults();
        test_threshold();
        test_saturation();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (150) @(posedge clk);
        $display("Run covered %0d sample beats, %0d checked results, %0d register writes,",
                 samples_sent, results_seen, cfg_writes);
        $display("threshold edges, %0d clamped duties and a long receiver hold-off.",
                 duty_clamps);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
